FILE: src/ibba_pkg.sv
package ibba_pkg;

  localparam int INODE_COUNT_DEF = 128;
  localparam logic [13:0] BUDGET_RESET = 14'd973;

  // in-use bits are kept in rows of this many inodes
  localparam int ROW_W    = 16;
  localparam int ROW_BITS = 4;

  localparam logic [14:0] DIRECT_MAX   = 15'd12;
  localparam logic [14:0] PTRS_PER_IDX = 15'd256;
  localparam logic [14:0] SINGLE_LIMIT = 15'd268;
  localparam logic [14:0] DBL_SAT      = 15'd16383;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_INODE  = 2'd1;
  localparam logic [1:0] STAT_NO_BLOCKS = 2'd2;
  localparam logic [1:0] STAT_NOT_USED  = 2'd3;

  typedef struct packed {
    logic [3:0]  direct;
    logic [8:0]  single_ind;
    logic [13:0] double_ind;
    logic [14:0] total;
  } split_t;

  // Split a byte size into direct, single-indirect and double-indirect blocks.
  function automatic split_t split_size(input logic [23:0] size);
    logic [14:0] data;
    logic [14:0] rest;
    logic [14:0] left;
    logic [14:0] dbl_full;
    split_t      s;
    data = (size == 24'd0) ? 15'd1 : 15'((size - 24'd1) >> 10) + 15'd1;
    s.direct = (data < DIRECT_MAX) ? data[3:0] : DIRECT_MAX[3:0];
    rest = data - DIRECT_MAX;
    if (data > DIRECT_MAX) begin
      s.single_ind = (rest < PTRS_PER_IDX) ? 9'(rest) + 9'd1 : 9'(PTRS_PER_IDX) + 9'd1;
    end else begin
      s.single_ind = 9'd0;
    end
    left = data - SINGLE_LIMIT;
    if (data > SINGLE_LIMIT) begin
      dbl_full = 15'((left - 15'd1) >> 8) + 15'd2 + left;
    end else begin
      dbl_full = 15'd0;
    end
    s.double_ind = (dbl_full > DBL_SAT) ? DBL_SAT[13:0] : dbl_full[13:0];
    s.total = 15'(s.direct) + 15'(s.single_ind) + dbl_full;
    return s;
  endfunction

  // Position of the lowest set bit of a row (zero when none is set).
  function automatic logic [ROW_BITS-1:0] lowest_set(input logic [ROW_W-1:0] v);
    logic [ROW_BITS-1:0] r;
    r = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = ROW_BITS'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: src/inode_block_budget_allocator.sv
// Inode table and disk block budget allocator.
//
// Input channel (in_valid/in_ready): operation, file_size, target_inode.
// Create takes the lowest free inode when the file's blocks (data plus
// index blocks) fit in block_budget; remove frees an inode and returns its
// blocks; query reports an inode's block split. One result item comes out
// on the output channel (out_valid/out_ready) for every input item.
//
// Sequence: one item at a time. Each item passes the steps accept, memory
// read, update and result load; the result is loaded into the output
// register once that register is free. A successful create adds a search
// for the next free inode over the in-use row memory, which first checks
// the row just written and then reads each further row in turn (rows hold
// 16 inodes each) until a free inode or the table's end is found.
// The result sits in an output register; while the receiver stalls the
// block finishes the item and waits with the next result only.
// Reset clears all inodes (row valid bits, no clearing pass), the used
// block count and the free-inode pointer, and sets block_budget to 973.
// cfg_wen writes block_budget; write it only while the block is idle.
module inode_block_budget_allocator #(
  parameter int INODE_COUNT = ibba_pkg::INODE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [23:0] file_size,
  input  logic [6:0]  target_inode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [6:0]  inode_number,
  output logic [13:0] free_blocks,
  output logic [3:0]  direct_blocks,
  output logic [8:0]  single_indirect_blocks,
  output logic [13:0] double_indirect_blocks,
  input  logic        cfg_wen,
  input  logic [13:0] cfg_wdata
);
  import ibba_pkg::*;

  localparam int IW   = $clog2(INODE_COUNT);
  localparam int ROWS = (INODE_COUNT + ROW_W - 1) / ROW_W;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW   = (IW + 1 > 7) ? IW + 1 : 7;
  localparam int MW   = ROW_BITS + RW + 1;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_READ      = 3'd1;
  localparam logic [2:0] S_EXEC      = 3'd2;
  localparam logic [2:0] S_RESULT    = 3'd3;
  localparam logic [2:0] S_SCAN      = 3'd4;
  localparam logic [2:0] S_SCAN_WAIT = 3'd5;

  logic [2:0]       state;
  logic [13:0]      budget;
  logic [13:0]      used;
  logic [IW:0]      low_free;     // lowest free inode, INODE_COUNT when full
  logic [1:0]       op_r;
  logic [23:0]      size_r;
  logic [6:0]       target_r;
  logic             hit_r;
  logic [ROW_W-1:0] row_r;
  split_t           split_r;
  logic             need_scan;
  logic [RW-1:0]    scan_row;
  logic [ROW_W-1:0] scan_data;
  logic [1:0]       res_status;
  logic [6:0]       res_inum;
  split_t           res_counts;

  logic [CW-1:0]    tgt_in_w;
  logic [IW-1:0]    tgt_in_idx;
  logic [CW-1:0]    tgt_r_w;
  logic [IW-1:0]    tgt_idx;
  logic             tgt_in_range;
  logic [ROW_BITS-1:0] tgt_bit;
  logic [RW-1:0]    tgt_row;
  logic [IW-1:0]    lf_idx;
  logic [ROW_BITS-1:0] lf_bit;
  logic [RW-1:0]    lf_row;
  logic             has_free;
  logic             fits;
  logic             create_ok;
  logic             remove_ok;
  logic             out_load;
  logic [ROW_W-1:0] scan_mask;
  logic [ROW_W-1:0] scan_free;

  logic [RW-1:0]    map_raddr;
  logic             map_wen;
  logic [RW-1:0]    map_waddr;
  logic [ROW_W-1:0] map_wdata;
  logic [ROW_W-1:0] map_rdata;
  logic             size_wen;
  logic [23:0]      size_rdata;

  // Index decode of the incoming and the held target inode.
  assign tgt_in_w     = CW'(target_inode);
  assign tgt_in_idx   = tgt_in_w[IW-1:0];
  assign tgt_r_w      = CW'(target_r);
  assign tgt_idx      = tgt_r_w[IW-1:0];
  assign tgt_in_range = tgt_r_w < CW'(INODE_COUNT);
  assign tgt_bit      = ROW_BITS'(tgt_idx);
  assign tgt_row      = RW'(tgt_idx >> ROW_BITS);

  assign lf_idx   = low_free[IW-1:0];
  assign lf_bit   = ROW_BITS'(lf_idx);
  assign lf_row   = RW'(lf_idx >> ROW_BITS);
  assign has_free = low_free != (IW + 1)'(INODE_COUNT);
  assign fits     = (16'(used) + 16'(split_r.total)) <= 16'(budget);

  assign create_ok = (state == S_EXEC) && (op_r == OP_CREATE) && has_free && fits;
  assign remove_ok = (state == S_EXEC) && (op_r == OP_REMOVE) && hit_r;

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_RESULT) && (!out_valid || out_ready);

  // In-use row memory ports: read on accept and during the free search,
  // write back the modified row on a successful create or remove.
  always_comb begin
    if (state == S_SCAN) begin
      map_raddr = scan_row + RW'(1);
    end else if (operation == OP_CREATE) begin
      map_raddr = lf_row;
    end else begin
      map_raddr = RW'(tgt_in_idx >> ROW_BITS);
    end
  end

  assign map_wen   = create_ok || remove_ok;
  assign map_waddr = (op_r == OP_CREATE) ? lf_row : tgt_row;
  assign map_wdata = (op_r == OP_CREATE) ? (row_r | (ROW_W'(1) << lf_bit))
                                         : (row_r & ~(ROW_W'(1) << tgt_bit));
  assign size_wen  = create_ok;

  // Rows may run past the table's end; those slots never count as free.
  always_comb begin
    for (int b = 0; b < ROW_W; b++) begin
      scan_mask[b] = MW'({scan_row, ROW_BITS'(b)}) < MW'(INODE_COUNT);
    end
  end
  assign scan_free = ~scan_data & scan_mask;

  ibba_inode_map #(
    .ROWS (ROWS),
    .RW   (RW)
  ) u_map (
    .clk   (clk),
    .rst   (rst),
    .raddr (map_raddr),
    .wen   (map_wen),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .rdata (map_rdata)
  );

  ibba_size_store #(
    .INODE_COUNT (INODE_COUNT)
  ) u_size (
    .clk   (clk),
    .raddr (tgt_in_idx),
    .wen   (size_wen),
    .waddr (lf_idx),
    .wdata (size_r),
    .rdata (size_rdata)
  );

  // Budget register, written from the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= BUDGET_RESET;
    end else if (cfg_wen) begin
      budget <= cfg_wdata;
    end
  end

  // Sequencer and table state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      low_free  <= '0;
      need_scan <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          need_scan <= create_ok;
          if (create_ok) begin
            used <= 14'(used + split_r.total[13:0]);
          end
          if (remove_ok) begin
            used <= (15'(used) >= split_r.total) ? (used - split_r.total[13:0]) : '0;
            if ((IW + 1)'(tgt_idx) < low_free) begin
              low_free <= (IW + 1)'(tgt_idx);
            end
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_load) begin
            state <= need_scan ? S_SCAN : S_IDLE;
          end
        end
        S_SCAN: begin
          if (|scan_free) begin
            low_free <= (IW + 1)'({scan_row, lowest_set(scan_free)});
            state    <= S_IDLE;
          end else if (scan_row == RW'(ROWS - 1)) begin
            low_free <= (IW + 1)'(INODE_COUNT);
            state    <= S_IDLE;
          end else begin
            state <= S_SCAN_WAIT;
          end
        end
        S_SCAN_WAIT: begin
          state <= S_SCAN;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item payload and per-item results.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r     <= operation;
      size_r   <= file_size;
      target_r <= target_inode;
    end
    if (state == S_READ) begin
      hit_r   <= ((op_r == OP_REMOVE) || (op_r == OP_QUERY)) && tgt_in_range
                 && map_rdata[tgt_bit];
      row_r   <= map_rdata;
      split_r <= split_size((op_r == OP_CREATE) ? size_r : size_rdata);
    end
    if (state == S_EXEC) begin
      if (op_r == OP_CREATE) begin
        res_counts <= split_r;
        if (!has_free) begin
          res_status <= STAT_NO_INODE;
          res_inum   <= '0;
        end else if (!fits) begin
          res_status <= STAT_NO_BLOCKS;
          res_inum   <= '0;
        end else begin
          res_status <= STAT_OK;
          res_inum   <= 7'(lf_idx);
          scan_row   <= lf_row;
          scan_data  <= map_wdata;
        end
      end else begin
        res_inum <= target_r;
        if (hit_r) begin
          res_status <= STAT_OK;
          res_counts <= split_r;
        end else begin
          res_status <= STAT_NOT_USED;
          res_counts <= '0;
        end
      end
    end
    if (state == S_SCAN_WAIT) begin
      scan_row  <= scan_row + RW'(1);
      scan_data <= map_rdata;
    end
  end

  // Output register: load the finished item, hold it until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status                 <= res_status;
      inode_number           <= res_inum;
      free_blocks            <= (used >= budget) ? '0 : (budget - used);
      direct_blocks          <= res_counts.direct;
      single_indirect_blocks <= res_counts.single_ind;
      double_indirect_blocks <= res_counts.double_ind;
    end
  end

endmodule

FILE: src/ibba_size_store.sv
module ibba_size_store #(
  parameter int INODE_COUNT = ibba_pkg::INODE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic [$clog2(INODE_COUNT)-1:0] raddr,
  input  logic                           wen,
  input  logic [$clog2(INODE_COUNT)-1:0] waddr,
  input  logic [23:0]                    wdata,
  output logic [23:0]                    rdata
);
  import ibba_pkg::*;

  logic [23:0] mem [INODE_COUNT];

  // entries are read only for inodes in use, so no reset is needed
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/ibba_inode_map.sv
module ibba_inode_map #(
  parameter int ROWS = (ibba_pkg::INODE_COUNT_DEF + ibba_pkg::ROW_W - 1) / ibba_pkg::ROW_W,
  parameter int RW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [RW-1:0]                raddr,
  input  logic                         wen,
  input  logic [RW-1:0]                waddr,
  input  logic [ibba_pkg::ROW_W-1:0]   wdata,
  output logic [ibba_pkg::ROW_W-1:0]   rdata
);
  import ibba_pkg::*;

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_valid;
  logic [ROW_W-1:0] data_q;
  logic             valid_q;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    data_q <= mem[raddr];
  end

  // a row never written reads as all free
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (wen) begin
        row_valid[waddr] <= 1'b1;
      end
      valid_q <= row_valid[raddr];
    end
  end

  assign rdata = valid_q ? data_q : '0;

endmodule

FILE: tb/inode_block_budget_allocator_test.sv
module inode_block_budget_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ibba_pkg::*;

  localparam int TABLE_SIZE      = 128;
  localparam int BLOCK_BYTES     = 1024;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int REPORT_LIMIT    = 10;

  // operation code the block does not define; it must act as a query of an unused inode
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  logic        clk;
  logic        rst                    = 1'b1;
  logic        in_valid               = 1'b0;
  logic        in_ready;
  logic [1:0]  operation              = OP_QUERY;
  logic [23:0] file_size              = '0;
  logic [6:0]  target_inode           = '0;
  logic        out_valid;
  logic        out_ready              = 1'b0;
  logic [1:0]  status;
  logic [6:0]  inode_number;
  logic [13:0] free_blocks;
  logic [3:0]  direct_blocks;
  logic [8:0]  single_indirect_blocks;
  logic [13:0] double_indirect_blocks;
  logic        cfg_wen                = 1'b0;
  logic [13:0] cfg_wdata              = '0;

  // block split of one file, unsaturated, with its total
  typedef struct packed {
    int unsigned direct;
    int unsigned single_ind;
    int unsigned double_ind;
    int unsigned total;
  } block_split_t;

  // one result item as the block reports it
  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  inode;
    logic [13:0] free;
    logic [3:0]  direct;
    logic [8:0]  single_ind;
    logic [13:0] double_ind;
  } alloc_result_t;

  // shadow of the inode table, the block count and the budget
  logic        inode_used [TABLE_SIZE];
  logic [23:0] inode_bytes [TABLE_SIZE];
  int unsigned blocks_in_use = 0;
  int unsigned budget        = BUDGET_RESET;
  int          live_files    = 0;

  alloc_result_t pending_results [$];

  int  items_sent       = 0;
  int  mismatches       = 0;
  int  unexpected       = 0;
  int  status_seen [4]  = '{0, 0, 0, 0};
  bit  sender_idling    = 1'b1;
  bit  sink_stalling    = 1'b1;
  bit  hold_off_request = 1'b0;

  inode_block_budget_allocator dut (
    .clk                    (clk),
    .rst                    (rst),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .operation              (operation),
    .file_size              (file_size),
    .target_inode           (target_inode),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .status                 (status),
    .inode_number           (inode_number),
    .free_blocks            (free_blocks),
    .direct_blocks          (direct_blocks),
    .single_indirect_blocks (single_indirect_blocks),
    .double_indirect_blocks (double_indirect_blocks),
    .cfg_wen                (cfg_wen),
    .cfg_wdata              (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Split a byte size into direct, single-indirect and double-indirect blocks.
  // A zero size still takes one data block.
  function automatic block_split_t compute_block_split(input logic [23:0] bytes);
    block_split_t s;
    int unsigned  data_blocks;
    int unsigned  over;
    s = '0;
    data_blocks = (bytes == 24'd0) ? 1 : (int'(bytes) - 1) / BLOCK_BYTES + 1;
    s.direct = (data_blocks < 32'(DIRECT_MAX)) ? data_blocks : 32'(DIRECT_MAX);
    if (data_blocks > 32'(DIRECT_MAX)) begin
      over = data_blocks - 32'(DIRECT_MAX);
      s.single_ind = 1 + ((over < 32'(PTRS_PER_IDX)) ? over : 32'(PTRS_PER_IDX));
    end
    if (data_blocks > 32'(SINGLE_LIMIT)) begin
      // top index block, one second-level index per 256 data blocks, data
      over = data_blocks - 32'(SINGLE_LIMIT);
      s.double_ind = (over - 1) / 32'(PTRS_PER_IDX) + 2 + over;
    end
    s.total = s.direct + s.single_ind + s.double_ind;
    return s;
  endfunction

  // Work out the result of one accepted item and advance the shadow table.
  function automatic alloc_result_t predict_allocation(input logic [1:0] op,
                                                       input logic [23:0] bytes,
                                                       input logic [6:0] target);
    alloc_result_t r;
    block_split_t  s;
    int            slot;
    r = '0;
    s = '0;
    slot = -1;
    if (op == OP_CREATE) begin
      s = compute_block_split(bytes);
      for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
        if (!inode_used[i]) slot = i;
      end
      // a full table is reported ahead of a lack of blocks
      if (slot < 0) begin
        r.status = STAT_NO_INODE;
      end else if (blocks_in_use + s.total > budget) begin
        r.status = STAT_NO_BLOCKS;
      end else begin
        r.status = STAT_OK;
        r.inode = 7'(slot);
        inode_used[slot] = 1'b1;
        inode_bytes[slot] = bytes;
        blocks_in_use = blocks_in_use + s.total;
        live_files++;
      end
    end else begin
      r.inode = target;
      if ((op == OP_REMOVE || op == OP_QUERY) && inode_used[target]) begin
        r.status = STAT_OK;
        s = compute_block_split(inode_bytes[target]);
        if (op == OP_REMOVE) begin
          blocks_in_use = (blocks_in_use >= s.total) ? blocks_in_use - s.total : 0;
          inode_used[target] = 1'b0;
          live_files--;
        end
      end else begin
        r.status = STAT_NOT_USED;
      end
    end
    // a budget lowered below the blocks in use reads as nothing free
    r.free = (blocks_in_use >= budget) ? 14'd0 : 14'(budget - blocks_in_use);
    r.direct = 4'(s.direct);
    r.single_ind = 9'(s.single_ind);
    r.double_ind = (s.double_ind > 32'(DBL_SAT)) ? DBL_SAT[13:0] : 14'(s.double_ind);
    return r;
  endfunction

  // Pick a live inode most of the time, otherwise any inode number.
  function automatic logic [6:0] pick_target();
    int unsigned live [$];
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (inode_used[i]) live = {live, 32'(i)};
    end
    if (live.size() == 0 || $urandom_range(0, 9) == 0) return 7'($urandom);
    return 7'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  // Mostly small files, some large, some exactly on a block or pointer boundary.
  function automatic logic [23:0] pick_file_size();
    int k;
    case ($urandom_range(0, 9))
      0: return 24'($urandom_range(1, 12288));
      1, 2, 3, 4, 5: return 24'($urandom_range(1, 300000));
      6, 7: return 24'($urandom_range(1, 2000000));
      8: return 24'($urandom);
      default: begin
        case ($urandom_range(0, 2))
          0: k = int'(DIRECT_MAX);
          1: k = int'(SINGLE_LIMIT);
          default: k = $urandom_range(0, 16384);
        endcase
        // k of 16384 wraps to a size of zero or one
        return 24'(k * BLOCK_BYTES + $urandom_range(0, 1));
      end
    endcase
  endfunction

  // Offer one item, hold it until accepted, then record what it must produce.
  task automatic send_item(input logic [1:0] op, input logic [23:0] bytes,
                           input logic [6:0] target);
    if (sender_idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    file_size    <= bytes;
    target_inode <= target;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results = {pending_results, predict_allocation(op, bytes, target)};
    items_sent++;
  endtask

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 8) begin
      send_item(OP_CREATE, pick_file_size(), 7'($urandom));
    end else if (pick < 13) begin
      send_item(OP_REMOVE, 24'($urandom), pick_target());
    end else if (pick < 19) begin
      send_item(OP_QUERY, 24'($urandom), pick_target());
    end else begin
      send_item(OP_UNKNOWN, 24'($urandom), 7'($urandom));
    end
  endtask

  // Drop valid and wait until every result is in and the block has settled.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the budget register, only with the block idle.
  task automatic write_budget(input logic [13:0] value);
    drain_block();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    budget = value;
  endtask

  // Block split at every boundary, under the reset budget of 973.
  task automatic test_block_split_edges();
    send_item(OP_CREATE, 24'd1, '0);
    send_item(OP_CREATE, 24'd0, '0);          // zero size: one data block
    send_item(OP_CREATE, 24'd1024, '0);
    send_item(OP_CREATE, 24'd1025, '0);
    send_item(OP_CREATE, 24'd12288, '0);      // all direct blocks
    send_item(OP_CREATE, 24'd12289, '0);      // first single-indirect block
    send_item(OP_CREATE, 24'd274432, '0);     // single indirect full
    send_item(OP_CREATE, 24'd274433, '0);     // first double-indirect block
    send_item(OP_CREATE, 24'hFFFFFF, 7'h7F);  // too big: counts still reported
  endtask

  // Query, remove and the unused-inode cases, then reuse of the freed inode.
  task automatic test_lookup_and_remove();
    send_item(OP_QUERY, 24'hFFFFFF, 7'd0);
    send_item(OP_QUERY, '0, 7'd7);
    send_item(OP_QUERY, '0, 7'd100);
    send_item(OP_REMOVE, '0, 7'd3);
    send_item(OP_QUERY, '0, 7'd3);
    send_item(OP_REMOVE, '0, 7'd3);
    send_item(OP_UNKNOWN, 24'hFFFFFF, 7'h7F);
    send_item(OP_UNKNOWN, '0, 7'd0);          // live inode, still unused status
    send_item(OP_CREATE, 24'd2048, 7'h55);    // must land on inode 3
    send_item(OP_QUERY, '0, 7'd3);
  endtask

  // Budget at both ends, including below the blocks already in use.
  task automatic test_budget_extremes();
    write_budget(14'd1);
    send_item(OP_CREATE, 24'd1, '0);
    send_item(OP_QUERY, '0, 7'd0);
    send_item(OP_REMOVE, '0, 7'd7);
    write_budget(14'd16383);
    send_item(OP_CREATE, 24'hFFFFFF, '0);
    send_item(OP_CREATE, 24'd16384000, '0);
  endtask

  // Empty the table, fill every inode, then overflow it.
  task automatic test_table_full();
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (inode_used[i]) send_item(OP_REMOVE, 24'($urandom), 7'(i));
    end
    while (live_files < TABLE_SIZE) begin
      send_item(OP_CREATE, 24'($urandom_range(0, 12288)), 7'($urandom));
    end
    send_item(OP_CREATE, 24'd1, '0);
    send_item(OP_CREATE, 24'hFFFFFF, '0);     // full table wins over too big
    send_item(OP_CREATE, 24'($urandom), 7'($urandom));
    // free random inodes and refill: the lowest free one must come back
    repeat (6) begin
      send_item(OP_REMOVE, 24'($urandom), pick_target());
      send_item(OP_CREATE, 24'($urandom_range(1, 12288)), 7'($urandom));
    end
    repeat (4) send_item(OP_QUERY, 24'($urandom), pick_target());
  endtask

  // Random traffic across several budgets.
  task automatic test_random_mix();
    for (int round = 0; round < 4; round++) begin
      case (round)
        0: write_budget(BUDGET_RESET);
        1: write_budget(14'($urandom_range(1, 16383)));
        2: write_budget(14'd16383);
        default: write_budget(14'($urandom_range(1, 400)));
      endcase
      repeat (50) send_random_item();
    end
  endtask

  // Hold the output off long enough for the block to stall its input.
  task automatic test_receiver_hold_off();
    write_budget(14'($urandom_range(2000, 16383)));
    hold_off_request = 1'b1;
    repeat (24) send_random_item();
  endtask

  // Last stretch with both sides running flat out.
  task automatic test_steady_stream();
    drain_block();
    sender_idling = 1'b0;
    sink_stalling = 1'b0;
    repeat (40) send_random_item();
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_off_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (sink_stalling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    alloc_result_t got;
    alloc_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{status, inode_number, free_blocks, direct_blocks,
              single_indirect_blocks, double_indirect_blocks};
      status_seen[got.status]++;
      if (pending_results.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= REPORT_LIMIT) begin
          $display("%0t: result with nothing expected: status %0d inode %0d free %0d",
                   $realtime, got.status, got.inode, got.free);
        end
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches + unexpected <= REPORT_LIMIT) begin
            $display("%0t: mismatch status %0d/%0d inode %0d/%0d free %0d/%0d (exp/act)",
                     $realtime, want.status, got.status, want.inode, got.inode,
                     want.free, got.free);
            $display("    direct %0d/%0d single %0d/%0d double %0d/%0d",
                     want.direct, got.direct, want.single_ind, got.single_ind,
                     want.double_ind, got.double_ind);
          end
        end
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("inode_block_budget_allocator regression: fail");
    $finish;
  end

  initial begin : run_tests
    int leftover;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      inode_used[i] = 1'b0;
      inode_bytes[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_block_split_edges();
    test_lookup_and_remove();
    test_budget_extremes();
    test_table_full();
    test_random_mix();
    test_receiver_hold_off();
    test_steady_stream();

    drain_block();
    leftover = pending_results.size();
    $display("ran %0d items: boundary sizes, a full table, budgets 1 to 16383,",
             items_sent);
    $display("  a %0d-cycle hold-off; ok %0d, no inode %0d, no blocks %0d, unused %0d",
             HOLD_OFF_CYCLES, status_seen[0], status_seen[1], status_seen[2],
             status_seen[3]);
    $display("mismatches %0d, extra %0d", mismatches, unexpected);
    if (mismatches == 0 && unexpected == 0 && leftover == 0) begin
      $display("inode_block_budget_allocator regression: pass");
    end else begin
      $display("inode_block_budget_allocator regression: fail");
    end
    $finish;
  end

endmodule
